// ===== rtl/ipr_pkg.sv =====
// Package for the inverse participation ratio block.
// Holds field widths, item and result types, controller states and the
// command and status groups shared by the controller and the division datapath.
package ipr_pkg;

	localparam int AMP_W   = 12;
	localparam int SQ_W    = 2 * AMP_W - 1;
	localparam int MAG2_W  = SQ_W + 1;
	localparam int MAG4_W  = 2 * MAG2_W - 1;
	localparam int NORM_W  = 34;
	localparam int QUART_W = 57;
	localparam int HALF_W  = NORM_W / 2;
	localparam int PROD_W  = NORM_W + HALF_W;
	localparam int DEN_W   = 2 * NORM_W;
	localparam int QUO_W   = 16;
	localparam int CNT_W   = 4;
	localparam int IPR_W   = 17;

	localparam logic [IPR_W-1:0] ONE_FIX = IPR_W'(65536);

	typedef struct packed {
		logic signed [AMP_W-1:0] amp_re;
		logic signed [AMP_W-1:0] amp_im;
		logic                    last;
	} sample_t;

	typedef struct packed {
		logic [IPR_W-1:0] ipr_value;
		logic             zero_norm;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_CMP,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_lo;
		logic mul_hi;
		logic cmp;
		logic step;
		logic set_zero;
		logic set_one;
	} div_cmd_t;

	typedef struct packed {
		logic zero;
		logic q_ge;
		logic last_step;
	} div_sts_t;

endpackage

// ===== rtl/ipr_acc.sv =====
// Front pipeline of the inverse participation ratio block: squares each
// amplitude, forms |a|^2 and |a|^4 and keeps the two saturating sums.
// Depends on ipr_pkg.
module ipr_acc #(
	parameter int AMP_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	input  ipr_pkg::sample_t             sample,
	input  logic                         busy,
	output logic                         stall,
	output logic                         load,
	output logic [ipr_pkg::NORM_W-1:0]   load_norm,
	output logic [ipr_pkg::QUART_W-1:0]  load_quart
);

	localparam int AW  = ipr_pkg::AMP_W;
	localparam int SW  = ipr_pkg::SQ_W;
	localparam int M2W = ipr_pkg::MAG2_W;
	localparam int M4W = ipr_pkg::MAG4_W;
	localparam int NW  = ipr_pkg::NORM_W;
	localparam int QW  = ipr_pkg::QUART_W;

	logic signed [AW-1:0]   re_x, im_x;
	logic signed [2*AW-1:0] re_p, im_p;
	logic [SW-1:0]          re_sq_s1, im_sq_s1;
	logic                   valid_s1, last_s1;
	logic [M2W-1:0]         mag2_c, mag2_s2;
	logic [M4W-1:0]         mag4_c, mag4_s2;
	logic                   valid_s2, last_s2;
	logic [NW-1:0]          norm_q, norm_sat;
	logic [QW-1:0]          quart_q, quart_sat;
	logic [NW:0]            nsum_c;
	logic [QW:0]            qsum_c;
	logic                   advance;

	assign re_x = AW'(signed'(sample.amp_re[AMP_BITS-1:0]));
	assign im_x = AW'(signed'(sample.amp_im[AMP_BITS-1:0]));
	assign re_p = re_x * re_x;
	assign im_p = im_x * im_x;

	assign mag2_c = M2W'(re_sq_s1) + M2W'(im_sq_s1);
	assign mag4_c = mag2_c * mag2_c;

	assign stall   = valid_s2 && last_s2 && busy;
	assign advance = !stall;
	assign load    = valid_s2 && last_s2 && !busy;

	assign nsum_c    = {1'b0, norm_q} + (NW + 1)'(mag2_s2);
	assign qsum_c    = {1'b0, quart_q} + (QW + 1)'(mag4_s2);
	assign norm_sat  = nsum_c[NW] ? '1 : nsum_c[NW-1:0];
	assign quart_sat = qsum_c[QW] ? '1 : qsum_c[QW-1:0];

	assign load_norm  = norm_sat;
	assign load_quart = quart_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= sample_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			re_sq_s1 <= re_p[SW-1:0];
			im_sq_s1 <= im_p[SW-1:0];
			last_s1  <= sample.last;
			mag2_s2  <= mag2_c;
			mag4_s2  <= mag4_c;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q  <= '0;
			quart_q <= '0;
		end else if (valid_s2 && advance) begin
			if (last_s2) begin
				norm_q  <= '0;
				quart_q <= '0;
			end else begin
				norm_q  <= norm_sat;
				quart_q <= quart_sat;
			end
		end
	end

endmodule

// ===== rtl/ipr_div.sv =====
// Division datapath: squares the norm in two partial products and forms
// the 16-bit fraction quartic_sum / norm_sum^2 one quotient bit a step.
// Depends on ipr_pkg.
module ipr_div (
	input  logic                         clk,
	input  ipr_pkg::div_cmd_t            cmd,
	input  logic [ipr_pkg::NORM_W-1:0]   load_norm,
	input  logic [ipr_pkg::QUART_W-1:0]  load_quart,
	output ipr_pkg::div_sts_t            sts,
	output ipr_pkg::result_t             result
);

	localparam int NW = ipr_pkg::NORM_W;
	localparam int QW = ipr_pkg::QUART_W;
	localparam int HW = ipr_pkg::HALF_W;
	localparam int PW = ipr_pkg::PROD_W;
	localparam int DW = ipr_pkg::DEN_W;
	localparam int UW = ipr_pkg::QUO_W;
	localparam int CW = ipr_pkg::CNT_W;
	localparam int RW = ipr_pkg::IPR_W;

	logic [NW-1:0]    n_q;
	logic [QW-1:0]    q_q;
	logic [DW-1:0]    den_q, rem_q;
	logic [UW-1:0]    quo_q;
	logic [CW-1:0]    cnt_q;
	ipr_pkg::result_t res_q;
	logic [HW-1:0]    mul_op;
	logic [PW-1:0]    prod_c;
	logic [DW:0]      sh_c, diff_c;
	logic             ge_c;

	assign mul_op = cmd.mul_hi ? n_q[NW-1:HW] : n_q[HW-1:0];
	assign prod_c = n_q * mul_op;

	assign sh_c   = {rem_q, 1'b0};
	assign diff_c = sh_c - {1'b0, den_q};
	assign ge_c   = sh_c >= {1'b0, den_q};

	assign sts.zero      = (n_q == '0);
	assign sts.q_ge      = DW'(q_q) >= den_q;
	assign sts.last_step = (cnt_q == '0);
	assign result        = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= load_norm;
			q_q <= load_quart;
		end
		if (cmd.mul_lo) begin
			den_q <= DW'(prod_c);
		end
		if (cmd.mul_hi) begin
			den_q <= den_q + {prod_c, {HW{1'b0}}};
		end
		if (cmd.cmp) begin
			rem_q <= DW'(q_q);
			quo_q <= '0;
			cnt_q <= CW'(UW - 1);
		end
		if (cmd.step) begin
			rem_q <= ge_c ? diff_c[DW-1:0] : sh_c[DW-1:0];
			quo_q <= {quo_q[UW-2:0], ge_c};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				res_q.ipr_value <= RW'({quo_q[UW-2:0], ge_c});
				res_q.zero_norm <= 1'b0;
			end
		end
		if (cmd.set_zero) begin
			res_q.ipr_value <= '0;
			res_q.zero_norm <= 1'b1;
		end
		if (cmd.set_one) begin
			res_q.ipr_value <= ipr_pkg::ONE_FIX;
			res_q.zero_norm <= 1'b0;
		end
	end

endmodule

// ===== rtl/ipr_ctrl.sv =====
// Controller of the inverse participation ratio block: sequences the
// norm squaring, the range check, the quotient steps and the result hand-off.
// Depends on ipr_pkg.
module ipr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ipr_pkg::div_sts_t sts,
	input  logic              result_stall,
	output ipr_pkg::div_cmd_t cmd,
	output logic              result_valid,
	output logic              busy
);

	ipr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		result_valid = 1'b0;
		busy         = 1'b1;
		unique case (state_q)
			ipr_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = load;
				if (load) begin
					state_d = ipr_pkg::ST_MUL_LO;
				end
			end
			ipr_pkg::ST_MUL_LO: begin
				if (sts.zero) begin
					cmd.set_zero = 1'b1;
					state_d      = ipr_pkg::ST_DONE;
				end else begin
					cmd.mul_lo = 1'b1;
					state_d    = ipr_pkg::ST_MUL_HI;
				end
			end
			ipr_pkg::ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ipr_pkg::ST_CMP;
			end
			ipr_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				if (sts.q_ge) begin
					cmd.set_one = 1'b1;
					state_d     = ipr_pkg::ST_DONE;
				end else begin
					state_d = ipr_pkg::ST_DIV;
				end
			end
			ipr_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.last_step) begin
					state_d = ipr_pkg::ST_DONE;
				end
			end
			ipr_pkg::ST_DONE: begin
				result_valid = 1'b1;
				if (!result_stall) begin
					state_d = ipr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ipr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/inverse_participation_ratio.sv =====
// Inverse participation ratio of a streamed complex vector.
// Sample channel: one amplitude per item (amp_re, amp_im, last), taken one
// per cycle unless sample_stall is high. Result channel: one item per
// vector, after the item marked last: ipr_value = floor(65536 * sum|a|^4 /
// (sum|a|^2)^2), at most 65536, with zero_norm set and ipr_value 0 when
// every amplitude was zero. Sums saturate at all ones; the ratio is clamped
// to 65536 when the quartic sum reaches the squared norm. From the last
// item to its result the path runs through two squaring stages, the load
// of the divider, the two 34x17 partial products of the squared norm, one
// range check and 16 quotient steps of the restoring divider. Accumulation
// of the next vector runs during that division; the divider is the only
// shared unit, and sample_stall rises only when a last item reaches the
// sums while the previous result is still being divided or waits.
// While result_stall is high the result holds in its output register and
// accumulation continues until the next last item.
// Reset clears both sums, the pipeline valids and the controller.
// Depends on ipr_pkg, ipr_acc, ipr_div and ipr_ctrl.
module inverse_participation_ratio #(
	parameter int AMP_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  ipr_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output ipr_pkg::result_t result
);

	logic                        busy;
	logic                        acc_load;
	logic [ipr_pkg::NORM_W-1:0]  load_norm;
	logic [ipr_pkg::QUART_W-1:0] load_quart;
	ipr_pkg::div_cmd_t           cmd;
	ipr_pkg::div_sts_t           sts;

	ipr_acc #(
		.AMP_BITS(AMP_BITS)
	) u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample      (sample),
		.busy        (busy),
		.stall       (sample_stall),
		.load        (acc_load),
		.load_norm   (load_norm),
		.load_quart  (load_quart)
	);

	ipr_div u_div (
		.clk       (clk),
		.cmd       (cmd),
		.load_norm (load_norm),
		.load_quart(load_quart),
		.sts       (sts),
		.result    (result)
	);

	ipr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (acc_load),
		.sts         (sts),
		.result_stall(result_stall),
		.cmd         (cmd),
		.result_valid(result_valid),
		.busy        (busy)
	);

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.zero_norm |-> result.ipr_value == '0)
		else $error("zero norm result carries a nonzero value");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.ipr_value <= ipr_pkg::ONE_FIX)
		else $error("result above one");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> busy && !acc_load)
		else $error("sample stalled while divider free");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_load |=> busy && !result_valid)
		else $error("divider load did not start a division");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for inverse_participation_ratio: directed vectors,
// checked against typed results or a local model, and random vectors.
// Depends on ipr_pkg and the inverse_participation_ratio RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AMP_W = ipr_pkg::AMP_W;
	localparam int NORM_W = ipr_pkg::NORM_W;
	localparam int QUART_W = ipr_pkg::QUART_W;
	localparam int IPR_W = ipr_pkg::IPR_W;
	localparam int RAND_ITEMS = 1828;
	localparam int LONG_HOLD_AT = 40;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam logic [63:0] NORM_SAT = (64'd1 << NORM_W) - 64'd1;
	localparam logic [63:0] QUART_SAT = (64'd1 << QUART_W) - 64'd1;

	typedef struct {
		ipr_pkg::sample_t s;
		bit               typed;
		ipr_pkg::result_t res;
	} vec_row_t;

	logic             clk;
	logic             arst_n;
	logic             sample_valid;
	logic             sample_stall;
	ipr_pkg::sample_t sample;
	logic             result_valid;
	logic             result_stall;
	ipr_pkg::result_t result;

	logic [NORM_W-1:0]  norm_acc;
	logic [QUART_W-1:0] quartic_acc;
	ipr_pkg::result_t   ipr_expect_q[$];
	ipr_pkg::result_t   head;
	int                 mismatch_cnt;
	vec_row_t           dir_tab[22];

	inverse_participation_ratio dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Accumulates one amplitude and, on the last one, forms the ratio and clears the sums.
	function automatic bit ipr_accumulate(input ipr_pkg::sample_t s,
			output ipr_pkg::result_t r);
		longint      re;
		longint      im;
		logic [63:0] mag2;
		logic [63:0] mag4;
		logic [63:0] nsum;
		logic [63:0] qsum;
		logic [127:0] num;
		logic [127:0] den;
		re = s.amp_re;
		im = s.amp_im;
		mag2 = 64'(re * re + im * im);
		mag4 = mag2 * mag2;
		nsum = 64'(norm_acc) + mag2;
		qsum = 64'(quartic_acc) + mag4;
		norm_acc = (nsum > NORM_SAT) ? NORM_SAT[NORM_W-1:0] : nsum[NORM_W-1:0];
		quartic_acc = (qsum > QUART_SAT) ? QUART_SAT[QUART_W-1:0] : qsum[QUART_W-1:0];
		r = '0;
		if (!s.last)
			return 1'b0;
		if (norm_acc == '0) begin
			r.zero_norm = 1'b1;
		end else begin
			num = 128'(quartic_acc) << 16;
			den = 128'(norm_acc) * 128'(norm_acc);
			if (num >= (den << 16))
				r.ipr_value = IPR_W'(65536);
			else
				r.ipr_value = IPR_W'(num / den);
		end
		norm_acc = '0;
		quartic_acc = '0;
		return 1'b1;
	endfunction

	task automatic drive_amp(input ipr_pkg::sample_t s, input int gap, input bit typed,
			input ipr_pkg::result_t typed_res);
		ipr_pkg::result_t r;
		bit               emit;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		emit = ipr_accumulate(s, r);
		if (emit)
			ipr_expect_q.push_back(typed ? typed_res : r);
	endtask

	function automatic logic [AMP_W-1:0] pick_amp(input int style);
		logic [AMP_W-1:0] corner[4];
		corner = '{12'h800, 12'h7FF, 12'h000, 12'hFFF};
		if (style != 3 && $urandom_range(0, 9) == 0)
			return corner[$urandom_range(0, 3)];
		case (style)
			0: return AMP_W'($urandom_range(0, 4095));
			1: return AMP_W'(int'($urandom_range(0, 8)) - 4);
			2: return corner[$urandom_range(0, 3)];
			default: return '0;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (ipr_expect_q.size() == 0) begin
				$error("unexpected result: ipr_value %0d zero_norm %0d",
					result.ipr_value, result.zero_norm);
				mismatch_cnt++;
			end else begin
				head = ipr_expect_q.pop_front();
				if (result.ipr_value !== head.ipr_value) begin
					$error("ipr_value: expected %0d, actual %0d",
						head.ipr_value, result.ipr_value);
					mismatch_cnt++;
				end
				if (result.zero_norm !== head.zero_norm) begin
					$error("zero_norm: expected %0d, actual %0d",
						head.zero_norm, result.zero_norm);
					mismatch_cnt++;
				end
			end
		end
	end

	// The result side may stall before each item, and once for a long stretch so that the block backs up.
	initial begin : result_sink
		int hold;
		int taken;
		taken = 0;
		result_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken == LONG_HOLD_AT)
				hold = LONG_HOLD_CYCLES;
			else if ($urandom_range(0, 2) == 0)
				hold = 0;
			else
				hold = $urandom_range(0, 19);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("inverse_participation_ratio verification failed");
		$finish;
	end

	initial begin : stimulus
		ipr_pkg::sample_t s;
		int               sent;
		int               len;
		int               style;
		int               gap_mode;
		int               gap;
		int               pick;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		mismatch_cnt = 0;
		norm_acc = '0;
		quartic_acc = '0;
		dir_tab = '{
			'{'{12'sd0, 12'sd0, 1'b1}, 1'b1, '{17'd0, 1'b1}},
			'{'{12'sd2047, 12'sd2047, 1'b1}, 1'b1, '{17'd65536, 1'b0}},
			'{'{-12'sd2048, -12'sd2048, 1'b1}, 1'b1, '{17'd65536, 1'b0}},
			'{'{-12'sd2048, 12'sd2047, 1'b1}, 1'b1, '{17'd65536, 1'b0}},
			'{'{12'sd1, 12'sd0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
			'{'{12'sd0, -12'sd1, 1'b1}, 1'b1, '{17'd32768, 1'b0}},
			'{'{12'sd0, 12'sd0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
			'{'{12'sd0, 12'sd0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
			'{'{12'sd0, 12'sd0, 1'b1}, 1'b1, '{17'd0, 1'b1}},
			'{'{12'sd0, 12'sd0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
			'{'{-12'sd5, 12'sd0, 1'b1}, 1'b1, '{17'd65536, 1'b0}},
			'{'{12'sd2047, 12'sd0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
			'{'{12'sd0, -12'sd2048, 1'b0}, 1'b0, '{17'd0, 1'b0}},
			'{'{-12'sd2048, 12'sd2047, 1'b0}, 1'b0, '{17'd0, 1'b0}},
			'{'{-12'sd1, -12'sd1, 1'b1}, 1'b0, '{17'd0, 1'b0}},
			'{'{12'sd3, 12'sd0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
			'{'{12'sd0, 12'sd3, 1'b0}, 1'b0, '{17'd0, 1'b0}},
			'{'{-12'sd3, 12'sd0, 1'b0}, 1'b0, '{17'd0, 1'b0}},
			'{'{12'sd0, -12'sd3, 1'b1}, 1'b1, '{17'd16384, 1'b0}},
			'{'{-12'sd2048, -12'sd2048, 1'b0}, 1'b0, '{17'd0, 1'b0}},
			'{'{-12'sd2048, -12'sd2048, 1'b1}, 1'b1, '{17'd32768, 1'b0}},
			'{'{12'sd2047, -12'sd2048, 1'b1}, 1'b1, '{17'd65536, 1'b0}}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			drive_amp(dir_tab[i].s, $urandom_range(0, 1) ? $urandom_range(0, 19) : 0,
				dir_tab[i].typed, dir_tab[i].res);

		sent = 0;
		while (sent < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				len = 1;
			else if (pick < 80)
				len = $urandom_range(2, 8);
			else if (pick < 95)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(41, 200);
			pick = $urandom_range(0, 99);
			style = (pick < 45) ? 0 : (pick < 75) ? 1 : (pick < 94) ? 2 : 3;
			gap_mode = $urandom_range(0, 2);
			for (int k = 0; k < len; k++) begin
				s.amp_re = pick_amp(style);
				s.amp_im = pick_amp(style);
				s.last = (k == len - 1);
				if (gap_mode == 0)
					gap = 0;
				else
					gap = $urandom_range(0, 1) ? $urandom_range(0, 19) : 0;
				drive_amp(s, gap, 1'b0, '0);
				sent++;
			end
		end
		sample_valid <= 1'b0;

		while (ipr_expect_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("inverse_participation_ratio verification clean");
		else
			$display("inverse_participation_ratio verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/ipr_pkg.sv
rtl/ipr_acc.sv
rtl/ipr_div.sv
rtl/ipr_ctrl.sv
rtl/inverse_participation_ratio.sv
sim/tb.sv
